// ===== hdl/rgb_to_yuv420_planar_stream_core_defines.svh =====
// Assertion macros shared by the RGB to YUV 4:2:0 stream core.
// Depends on nothing; included by the top level only.
`ifndef RGB_TO_YUV420_PLANAR_STREAM_CORE_DEFINES_SVH
`define RGB_TO_YUV420_PLANAR_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RYUV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RYUV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ryuv_pkg.sv =====
// Shared types and constants for the RGB to YUV 4:2:0 stream core.
// No dependencies; used by every module of the block.
package ryuv_pkg;

    localparam int CFG_W     = 13;
    localparam int COUNT_W   = 12;
    localparam int LUMA_W    = 24;
    localparam int OFF_W     = 25;
    localparam int PIX_W     = 8;
    localparam int PLANE_W   = 2;

    localparam logic [CFG_W-1:0] MAX_WIDTH     = 13'd4096;
    localparam logic [CFG_W-1:0] MAX_HEIGHT    = 13'd4096;
    localparam logic [CFG_W-1:0] MIN_WIDTH     = 13'd2;
    localparam logic [CFG_W-1:0] MIN_HEIGHT    = 13'd1;
    localparam logic [CFG_W-1:0] RESET_WIDTH   = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT  = 13'd480;

    // Register indexes on the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Plane codes
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One converted pixel waiting for the back end
    typedef struct packed {
        logic [LUMA_W-1:0] luma_off;
        logic [OFF_W-1:0]  u_off;
        logic [OFF_W-1:0]  v_off;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  u;
        logic [PIX_W-1:0]  v;
        logic              chroma;
        logic              eof;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== hdl/ryuv_front.sv =====
// Front end: configuration registers, raster position, offsets and color math.
// Depends on ryuv_pkg; produces one job per accepted pixel.
module ryuv_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [ryuv_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_accept,
    input  logic [ryuv_pkg::PIX_W-1:0]        i_red,
    input  logic [ryuv_pkg::PIX_W-1:0]        i_green,
    input  logic [ryuv_pkg::PIX_W-1:0]        i_blue,
    output ryuv_pkg::t_job                    o_job
);

    logic [ryuv_pkg::CFG_W-1:0]   r_cfg_w, r_cfg_h;
    logic [ryuv_pkg::COUNT_W-1:0] r_col, r_line, n_col, n_line;
    logic [ryuv_pkg::LUMA_W-1:0]  r_luma, n_luma;
    logic [ryuv_pkg::OFF_W-1:0]   r_u_off, r_v_off;

    logic [ryuv_pkg::CFG_W-1:0]   w_even, eff_w, h_raw, eff_h;
    logic [2*ryuv_pkg::CFG_W-1:0] prod;
    logic [ryuv_pkg::OFF_W-1:0]   frame_size, v_base, cur_u, cur_v;
    logic [ryuv_pkg::CFG_W-1:0]   col_inc, line_inc;
    logic                         frame_start, wrap_col, eof, chroma;
    logic [15:0]                  y_sum, u_sum, v_sum;
    logic [15:0]                  r16, g16, b16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= ryuv_pkg::RESET_WIDTH;
            r_cfg_h <= ryuv_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ryuv_pkg::REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                ryuv_pkg::REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_even = {r_cfg_w[ryuv_pkg::CFG_W-1:1], 1'b0};
        if (w_even < ryuv_pkg::MIN_WIDTH)
            eff_w = ryuv_pkg::MIN_WIDTH;
        else if (w_even > ryuv_pkg::MAX_WIDTH)
            eff_w = ryuv_pkg::MAX_WIDTH;
        else
            eff_w = w_even;

        h_raw = r_cfg_h;
        if (h_raw < ryuv_pkg::MIN_HEIGHT)
            eff_h = ryuv_pkg::MIN_HEIGHT;
        else if (h_raw > ryuv_pkg::MAX_HEIGHT)
            eff_h = ryuv_pkg::MAX_HEIGHT;
        else
            eff_h = h_raw;

        prod       = (2*ryuv_pkg::CFG_W)'(eff_w) * (2*ryuv_pkg::CFG_W)'(eff_h);
        frame_size = prod[ryuv_pkg::OFF_W-1:0];
        v_base     = frame_size + {2'b00, frame_size[ryuv_pkg::OFF_W-1:2]};

        // Chroma bases reload on the first pixel of a frame
        frame_start = (r_col == '0) && (r_line == '0);
        cur_u = frame_start ? frame_size : r_u_off;
        cur_v = frame_start ? v_base : r_v_off;

        col_inc  = {1'b0, r_col} + ryuv_pkg::CFG_W'(1);
        line_inc = {1'b0, r_line} + ryuv_pkg::CFG_W'(1);
        wrap_col = (col_inc >= eff_w);
        eof      = wrap_col && (line_inc >= eff_h);
        chroma   = !r_col[0] && !r_line[0];

        n_col  = wrap_col ? '0 : col_inc[ryuv_pkg::COUNT_W-1:0];
        n_line = eof ? '0 : (wrap_col ? line_inc[ryuv_pkg::COUNT_W-1:0] : r_line);
        n_luma = eof ? '0 : r_luma + ryuv_pkg::LUMA_W'(1);

        r16 = {8'd0, i_red};
        g16 = {8'd0, i_green};
        b16 = {8'd0, i_blue};
        // Sums stay in range, so 16-bit modular math is exact; U and V carry a 128*256 bias
        y_sum = r16 * 16'd66 + g16 * 16'd129 + b16 * 16'd25;
        u_sum = 16'd32768 + b16 * 16'd112 - r16 * 16'd38 - g16 * 16'd74;
        v_sum = 16'd32768 + r16 * 16'd112 - g16 * 16'd94 - b16 * 16'd18;

        o_job.luma_off = r_luma;
        o_job.u_off    = cur_u;
        o_job.v_off    = cur_v;
        o_job.y        = y_sum[15:8] + 8'd16;
        o_job.u        = u_sum[15:8];
        o_job.v        = v_sum[15:8];
        o_job.chroma   = chroma;
        o_job.eof      = eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_line <= '0;
            r_luma <= '0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_line <= n_line;
            r_luma <= n_luma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && chroma) begin
            r_u_off <= cur_u + ryuv_pkg::OFF_W'(1);
            r_v_off <= cur_v + ryuv_pkg::OFF_W'(1);
        end
    end

endmodule

// ===== hdl/ryuv_fifo.sv =====
// Short job queue between the front end and the back end.
// Depends on ryuv_pkg for the job type and depth.
module ryuv_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ryuv_pkg::t_job  i_job,
    input  logic            i_pop,
    output ryuv_pkg::t_job  o_job,
    output ryuv_pkg::t_qstat o_stat
);

    ryuv_pkg::t_job                   r_mem [ryuv_pkg::FIFO_DEPTH];
    logic [ryuv_pkg::FIFO_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [ryuv_pkg::FIFO_CNT_W-1:0]  r_count;
    logic                             do_push, do_pop;

    always_comb begin
        o_stat.empty = (r_count == '0);
        o_stat.full  = (r_count == ryuv_pkg::FIFO_CNT_W'(ryuv_pkg::FIFO_DEPTH));
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_job        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= r_wr_ptr + ryuv_pkg::FIFO_PTR_W'(1);
            if (do_pop)
                r_rd_ptr <= r_rd_ptr + ryuv_pkg::FIFO_PTR_W'(1);
            if (do_push && !do_pop)
                r_count <= r_count + ryuv_pkg::FIFO_CNT_W'(1);
            else if (do_pop && !do_push)
                r_count <= r_count - ryuv_pkg::FIFO_CNT_W'(1);
        end
    end

endmodule

// ===== hdl/ryuv_back.sv =====
// Back end: splits each job into a Y result, plus U and V results for a chroma pixel, into a registered output stage.
// Depends on ryuv_pkg for the job type and plane codes.
module ryuv_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ryuv_pkg::t_job                 i_job,
    input  ryuv_pkg::t_qstat               i_qstat,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_valid,
    output logic [ryuv_pkg::PLANE_W-1:0]   o_plane,
    output logic [ryuv_pkg::OFF_W-1:0]     o_byte_offset,
    output logic [ryuv_pkg::PIX_W-1:0]     o_sample,
    output logic                           o_last_of_run,
    output logic                           o_end_of_frame
);

    localparam logic [1:0] PH_Y = 2'd0;
    localparam logic [1:0] PH_U = 2'd1;
    localparam logic [1:0] PH_V = 2'd2;

    logic [1:0]                     r_phase, n_phase;
    logic                           r_valid;
    logic [ryuv_pkg::PLANE_W-1:0]   r_plane, n_plane;
    logic [ryuv_pkg::OFF_W-1:0]     r_off, n_off;
    logic [ryuv_pkg::PIX_W-1:0]     r_sample, n_sample;
    logic                           r_last, n_last, r_eof, n_eof;
    logic                           out_free, emit, last_phase;

    always_comb begin
        out_free = !r_valid || i_pop;
        emit     = !i_qstat.empty && out_free;

        n_plane  = ryuv_pkg::PLANE_Y;
        n_off    = {1'b0, i_job.luma_off};
        n_sample = i_job.y;
        n_last   = !i_job.chroma;
        n_eof    = !i_job.chroma && i_job.eof;
        last_phase = !i_job.chroma;
        n_phase  = PH_U;
        case (r_phase)
            PH_Y: begin
                n_phase = i_job.chroma ? PH_U : PH_Y;
            end
            PH_U: begin
                n_plane    = ryuv_pkg::PLANE_U;
                n_off      = i_job.u_off;
                n_sample   = i_job.u;
                n_last     = 1'b0;
                n_eof      = 1'b0;
                last_phase = 1'b0;
                n_phase    = PH_V;
            end
            PH_V: begin
                n_plane    = ryuv_pkg::PLANE_V;
                n_off      = i_job.v_off;
                n_sample   = i_job.v;
                n_last     = 1'b1;
                n_eof      = i_job.eof;
                last_phase = 1'b1;
                n_phase    = PH_Y;
            end
            default: begin
                n_phase    = PH_Y;
            end
        endcase
        // Drop the job from the queue once its final result is loaded
        o_q_pop = emit && last_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_Y;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_phase <= n_phase;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_plane  <= n_plane;
            r_off    <= n_off;
            r_sample <= n_sample;
            r_last   <= n_last;
            r_eof    <= n_eof;
        end
    end

    assign o_valid        = r_valid;
    assign o_plane        = r_plane;
    assign o_byte_offset  = r_off;
    assign o_sample       = r_sample;
    assign o_last_of_run  = r_last;
    assign o_end_of_frame = r_eof;

endmodule

// ===== hdl/rgb_to_yuv420_planar_stream_core.sv =====
// Top level of the RGB24 to planar YUV 4:2:0 stream core.
// Depends on ryuv_pkg, ryuv_front, ryuv_fifo, ryuv_back and the defines header.
//
//  Channel   Handshake          Payload
//  pixel     push / full        i_red, i_green, i_blue
//  result    empty / pop        o_plane, o_byte_offset, o_sample, o_last_of_run,
//                               o_end_of_frame
//  config    i_cfg_we           i_cfg_index, i_cfg_data
//
// A pixel is taken every cycle while the four-entry job queue has room.
// The output stage sends one result a cycle while the result side keeps popping:
// a Y result for a luma-only pixel, Y, U and V results for a chroma pixel.
// A taken pixel is registered in the job queue, then its first result in the output stage.
// Synchronous reset clears position counters, queue and output stage.
// A stall on the result side fills the queue, then raises full.
`include "rgb_to_yuv420_planar_stream_core_defines.svh"

module rgb_to_yuv420_planar_stream_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [ryuv_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [ryuv_pkg::PIX_W-1:0]     i_red,
    input  logic [ryuv_pkg::PIX_W-1:0]     i_green,
    input  logic [ryuv_pkg::PIX_W-1:0]     i_blue,
    output logic                           empty,
    input  logic                           pop,
    output logic [ryuv_pkg::PLANE_W-1:0]   o_plane,
    output logic [ryuv_pkg::OFF_W-1:0]     o_byte_offset,
    output logic [ryuv_pkg::PIX_W-1:0]     o_sample,
    output logic                           o_last_of_run,
    output logic                           o_end_of_frame
);

    ryuv_pkg::t_job   front_job, queue_job;
    ryuv_pkg::t_qstat qstat;
    logic             accept, q_pop, out_valid;

    assign accept = push && !qstat.full;
    assign full   = qstat.full;
    assign empty  = !out_valid;

    ryuv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_job       (front_job)
    );

    ryuv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (queue_job),
        .o_stat  (qstat)
    );

    ryuv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (queue_job),
        .i_qstat        (qstat),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_valid        (out_valid),
        .o_plane        (o_plane),
        .o_byte_offset  (o_byte_offset),
        .o_sample       (o_sample),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

    `RYUV_ASSERT_NEXT(a_u_then_v, i_clk, i_rst_n,
        (!empty && pop && o_plane == ryuv_pkg::PLANE_U),
        (!empty && o_plane == ryuv_pkg::PLANE_V), "V result did not follow U")
    `RYUV_ASSERT_NEXT(a_y_then_u, i_clk, i_rst_n,
        (!empty && pop && o_plane == ryuv_pkg::PLANE_Y && !o_last_of_run),
        (!empty && o_plane == ryuv_pkg::PLANE_U), "U result did not follow chroma Y")
    `RYUV_ASSERT_NOW(a_eof_is_last, i_clk, i_rst_n,
        (!empty && o_end_of_frame), o_last_of_run, "end of frame on a non-final result")

endmodule

// ===== tb/planar_byte_checker.sv =====
// Checker for the RGB to YUV 4:2:0 planar stream core: predicts the Y byte of every
// accepted pixel request, plus U and V bytes for chroma pixels, and compares them
// with the result channel. Depends on ryuv_pkg.
`timescale 1ns / 100ps

module planar_byte_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [ryuv_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         push,
    input  logic                         full,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_red,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_green,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_blue,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [ryuv_pkg::PLANE_W-1:0] i_plane,
    input  logic [ryuv_pkg::OFF_W-1:0]   i_byte_offset,
    input  logic [ryuv_pkg::PIX_W-1:0]   i_sample,
    input  logic                         i_last_of_run,
    input  logic                         i_end_of_frame,
    output int                           o_mismatches,
    output int                           o_pending_bytes
);
    import ryuv_pkg::*;

    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [OFF_W-1:0]   offset;
        logic [PIX_W-1:0]   sample;
        logic               last;
        logic               eof;
    } t_yuv_byte;

    t_yuv_byte         expected_bytes[$];
    t_yuv_byte         got;
    t_yuv_byte         want;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    int unsigned       col_cnt;
    int unsigned       line_cnt;
    logic [LUMA_W-1:0] luma_off;
    logic [OFF_W-1:0]  u_off;
    logic [OFF_W-1:0]  v_off;

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(width_reg & ~13'd1);
        if (w < MIN_WIDTH) w = 32'(MIN_WIDTH);
        if (w > MAX_WIDTH) w = 32'(MAX_WIDTH);
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = 32'(height_reg);
        if (h < MIN_HEIGHT) h = 32'(MIN_HEIGHT);
        if (h > MAX_HEIGHT) h = 32'(MAX_HEIGHT);
        return h;
    endfunction

    // U plane follows the full luma plane, V plane follows a quarter-size U plane
    task automatic load_chroma_bases();
        int unsigned frame_bytes;
        frame_bytes = active_width() * active_height();
        u_off = frame_bytes[OFF_W-1:0];
        v_off = OFF_W'(frame_bytes + frame_bytes / 4);
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                 input logic [PIX_W-1:0] b);
        int          rr, gg, bb, ys, us, vs;
        int unsigned w, h, next_col, next_line;
        logic        chroma, eof;
        rr = int'(r);
        gg = int'(g);
        bb = int'(b);
        w = active_width();
        h = active_height();
        if (col_cnt == 0 && line_cnt == 0) load_chroma_bases();
        ys = ((66 * rr + 129 * gg + 25 * bb) >>> 8) + 16;
        us = ((-38 * rr - 74 * gg + 112 * bb) >>> 8) + 128;
        vs = ((112 * rr - 94 * gg - 18 * bb) >>> 8) + 128;
        chroma = (line_cnt % 2 == 0) && (col_cnt % 2 == 0);
        next_col = col_cnt + 1;
        next_line = line_cnt;
        eof = 1'b0;
        // a count already past a shrunken bound ends the line or frame here
        if (next_col >= w) begin
            next_col = 0;
            next_line++;
            if (next_line >= h) begin
                next_line = 0;
                eof = 1'b1;
            end
        end
        expected_bytes.push_back('{PLANE_Y, {1'b0, luma_off}, ys[7:0], ~chroma, ~chroma & eof});
        if (chroma) begin
            expected_bytes.push_back('{PLANE_U, u_off, us[7:0], 1'b0, 1'b0});
            expected_bytes.push_back('{PLANE_V, v_off, vs[7:0], 1'b1, eof});
            u_off = u_off + 1'b1;
            v_off = v_off + 1'b1;
        end
        luma_off = eof ? '0 : luma_off + 1'b1;
        col_cnt = next_col;
        line_cnt = next_line;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            col_cnt = 0;
            line_cnt = 0;
            luma_off = '0;
            load_chroma_bases();
            expected_bytes.delete();
        end else begin
            // a pixel taken at this edge still sees the old registers
            if (push && !full) predict_pixel(i_red, i_green, i_blue);
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (pop && !empty) begin
                got = '{i_plane, i_byte_offset, i_sample, i_last_of_run, i_end_of_frame};
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: plane %0d offset %0d sample %0d",
                           got.plane, got.offset, got.sample);
                    o_mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("plane", want.plane, got.plane);
                    check_field("byte_offset", want.offset, got.offset);
                    check_field("sample", want.sample, got.sample);
                    check_field("last_of_run", want.last, got.last);
                    check_field("end_of_frame", want.eof, got.eof);
                end
            end
        end
        o_pending_bytes = expected_bytes.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the RGB to YUV 4:2:0 planar stream core test: clock, reset, pixel and
// register stimulus, result sink, verdict. Depends on ryuv_pkg, the core and
// planar_byte_checker.
`timescale 1ns / 100ps

module testbench;
    import ryuv_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [PIX_W-1:0]   i_red = '0;
    logic [PIX_W-1:0]   i_green = '0;
    logic [PIX_W-1:0]   i_blue = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [PLANE_W-1:0] o_plane;
    logic [OFF_W-1:0]   o_byte_offset;
    logic [PIX_W-1:0]   o_sample;
    logic               o_last_of_run;
    logic               o_end_of_frame;
    int                 mismatches;
    int                 pending_bytes;
    int                 burst_left = 0;
    int                 sink_mode = 0;
    int                 sink_left = 0;
    int                 sink_tick = 0;

    rgb_to_yuv420_planar_stream_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .empty(empty), .pop(pop), .o_plane(o_plane), .o_byte_offset(o_byte_offset),
        .o_sample(o_sample), .o_last_of_run(o_last_of_run), .o_end_of_frame(o_end_of_frame)
    );

    planar_byte_checker byte_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .push(push), .full(full), .i_red(i_red), .i_green(i_green), .i_blue(i_blue),
        .empty(empty), .pop(pop), .i_plane(o_plane), .i_byte_offset(o_byte_offset),
        .i_sample(o_sample), .i_last_of_run(o_last_of_run), .i_end_of_frame(o_end_of_frame),
        .o_mismatches(mismatches), .o_pending_bytes(pending_bytes)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result sink: switch between free-running, random and sparse pop patterns
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(32, 96);
        end
        sink_left--;
        sink_tick++;
        case (sink_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= (sink_tick % 4 == 0);
            default: pop <= (sink_tick % 9 == 0);
        endcase
    end

    function automatic logic [PIX_W-1:0] rand_component();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Hold the request until accepted, then pause between bursts
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        int gap;
        push <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (full);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input logic index, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending and wait until every predicted byte has come out
    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (pending_bytes != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int               rand_sent;
        int               n_pixels;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;
        rand_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: primaries and both extremes
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        drain_results();

        // Width and height below minimum, written mid-line
        write_reg(REG_FRAME_WIDTH, 13'd1);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h80, 8'h7F, 8'h01);
        send_pixel(8'h01, 8'hFE, 8'h80);
        drain_results();

        // Odd width and odd height, six pixels across an end of frame
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        drain_results();

        // Both above maximum, written mid-line
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        send_pixel(8'h12, 8'h34, 8'h56);
        send_pixel(8'hFE, 8'h01, 8'hFE);
        send_pixel(8'h00, 8'h00, 8'h00);
        drain_results();

        // Exact maximum, then shrink mid-frame to the minimum
        write_reg(REG_FRAME_WIDTH, MAX_WIDTH);
        write_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        drain_results();
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, MIN_HEIGHT);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        drain_results();

        // Random geometries, mostly tiny frames so many wrap
        while (rand_sent < 300) begin
            if ($urandom_range(0, 7) == 0) begin
                w_val = CFG_W'($urandom_range(0, 8191));
                h_val = CFG_W'($urandom_range(0, 8191));
                n_pixels = $urandom_range(3, 10);
            end else begin
                w_val = CFG_W'($urandom_range(0, 13));
                h_val = CFG_W'($urandom_range(0, 6));
                n_pixels = $urandom_range(10, 45);
            end
            if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, w_val);
            if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, h_val);
            repeat (n_pixels) send_pixel(rand_component(), rand_component(), rand_component());
            rand_sent += n_pixels;
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
